>>> src/isqrt_pkg.sv
// Shared constants and controller-to-datapath command type for the square root unit.
package isqrt_pkg;

   // Operand width; the root takes one bit per pair of operand bits.
   localparam int DATA_WIDTH = 32;
   localparam int ROOT_WIDTH = 16;
   localparam int STEPS      = DATA_WIDTH / 2;
   localparam int REM_WIDTH  = STEPS + 1;
   localparam int TRIAL_WIDTH = STEPS + 2;
   localparam int CNT_WIDTH  = $clog2(STEPS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

endpackage

>>> src/isqrt_ctrl.sv
// Sequencer for the square root unit: accepts an item, counts the steps, raises the strobe.
module isqrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output isqrt_pkg::cmd_type cmd,
   output logic               rsp_valid
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic [isqrt_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                          valid_ff, valid_in;
   logic                          last_step;

   assign last_step = (cnt_ff == isqrt_pkg::CNT_WIDTH'(isqrt_pkg::STEPS - 1));

   // Next state, step counter and result strobe.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (last_step) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

>>> src/isqrt_dp.sv
// Datapath for the square root unit: restoring square root, one root bit per step.
module isqrt_dp (
   input  logic                                  clock,
   input  isqrt_pkg::cmd_type                    cmd,
   input  logic signed [isqrt_pkg::DATA_WIDTH-1:0] req_operand,
   output logic        [isqrt_pkg::ROOT_WIDTH-1:0] rsp_root,
   output logic                                  rsp_negative_error
);

   logic [isqrt_pkg::DATA_WIDTH-1:0]  opnd_ff, opnd_in;
   logic [isqrt_pkg::REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [isqrt_pkg::STEPS-1:0]       root_ff, root_in;
   logic                              neg_ff, neg_in;
   logic [isqrt_pkg::TRIAL_WIDTH-1:0] rem_sh;
   logic [isqrt_pkg::TRIAL_WIDTH-1:0] trial;
   logic [isqrt_pkg::TRIAL_WIDTH-1:0] diff;

   // Bring in the next two operand bits and compare against 4r+1.
   assign rem_sh = {rem_ff[isqrt_pkg::STEPS-1:0],
                    opnd_ff[isqrt_pkg::DATA_WIDTH-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign diff   = rem_sh - trial;

   always_comb begin
      opnd_in = opnd_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      neg_in  = neg_ff;
      if (cmd.load) begin
         opnd_in = req_operand;
         rem_in  = '0;
         root_in = '0;
         neg_in  = req_operand[isqrt_pkg::DATA_WIDTH-1];
      end else if (cmd.step) begin
         opnd_in = {opnd_ff[isqrt_pkg::DATA_WIDTH-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = diff[isqrt_pkg::REM_WIDTH-1:0];
            root_in = {root_ff[isqrt_pkg::STEPS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[isqrt_pkg::REM_WIDTH-1:0];
            root_in = {root_ff[isqrt_pkg::STEPS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      neg_ff  <= neg_in;
   end

   // A negative operand has no root and reads as zero.
   assign rsp_root           = neg_ff ? '0 : (isqrt_pkg::ROOT_WIDTH)'(root_ff);
   assign rsp_negative_error = neg_ff;

endmodule

>>> src/integer_square_root_unit.sv
// Top level of the integer square root unit.
// Usage:
//   An item is taken at a rising edge with start high and busy low; req_operand is
//   a signed 32-bit value sampled at that edge.
//   The result appears on rsp_root and rsp_negative_error for exactly one cycle,
//   marked by rsp_valid, and is taken at the edge ending that cycle.
//   rsp_root is the floor of the square root; a negative operand gives root zero
//   with rsp_negative_error set.
// Sequencing:
//   The restoring square root resolves one root bit per cycle after the accept
//   edge. rsp_valid is registered and rises with the edge that stores the last
//   root bit, and the result is taken at the edge ending that cycle. Busy is low
//   again while the result is shown, so a new item may be accepted at that same
//   edge; no new item is taken while one is in progress.
// Reset:
//   Synchronous reset returns the sequencer to idle and clears the strobe; any
//   item in progress is dropped.
// Stalls:
//   The receiver cannot hold results off; each result is shown once.
module integer_square_root_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [isqrt_pkg::DATA_WIDTH-1:0] req_operand,
   output logic                                    rsp_valid,
   output logic        [isqrt_pkg::ROOT_WIDTH-1:0] rsp_root,
   output logic                                    rsp_negative_error
);

   isqrt_pkg::cmd_type cmd;

   // Sequencer.
   isqrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // Root datapath.
   isqrt_dp u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .req_operand        (req_operand),
      .rsp_root           (rsp_root),
      .rsp_negative_error (rsp_negative_error)
   );

endmodule

>>> dv/root_tracker_pkg.sv
`timescale 1ns / 100ps
// Record of expected square roots for the integer square root unit testbench.
package root_tracker_pkg;

   // One expected result item.
   typedef struct {
      logic [isqrt_pkg::ROOT_WIDTH-1:0] root;
      logic                             negative_error;
   } root_result_type;

   class root_tracker;

      root_result_type pending_roots[$];
      int unsigned     mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // Floor of the square root by the restoring method: one root bit per pair of operand bits.
      function automatic logic [isqrt_pkg::ROOT_WIDTH-1:0] floor_sqrt(
         logic [isqrt_pkg::DATA_WIDTH-1:0] value);
         logic [isqrt_pkg::STEPS+3:0] remainder;
         logic [isqrt_pkg::STEPS+3:0] trial;
         logic [isqrt_pkg::STEPS-1:0] root;
         remainder = '0;
         root      = '0;
         for (int i = isqrt_pkg::STEPS - 1; i >= 0; i--) begin
            remainder = {remainder[isqrt_pkg::STEPS+1:0], value[2*i+1 -: 2]};
            trial     = {2'b00, root, 2'b01};
            if (remainder >= trial) begin
               remainder = remainder - trial;
               root      = {root[isqrt_pkg::STEPS-2:0], 1'b1};
            end else begin
               root      = {root[isqrt_pkg::STEPS-2:0], 1'b0};
            end
         end
         // A root wider than the port wraps to its low bits.
         return root[isqrt_pkg::ROOT_WIDTH-1:0];
      endfunction

      // Works out the result for an accepted item and queues it.
      function void note_operand(logic signed [isqrt_pkg::DATA_WIDTH-1:0] operand);
         root_result_type expected;
         if (operand[isqrt_pkg::DATA_WIDTH-1]) begin
            expected.root           = '0;
            expected.negative_error = 1'b1;
         end else begin
            expected.root           = floor_sqrt(operand);
            expected.negative_error = 1'b0;
         end
         pending_roots.push_back(expected);
      endfunction

      // Compares a delivered result with the oldest one still outstanding.
      function void check_root(logic [isqrt_pkg::ROOT_WIDTH-1:0] root, logic negative_error);
         root_result_type expected;
         if (pending_roots.size() == 0) begin
            $display("%0t: result with nothing outstanding: root %0d, negative_error %0b",
                     $time, root, negative_error);
            mismatch_count++;
            return;
         end
         expected = pending_roots.pop_front();
         if (root !== expected.root) begin
            $display("%0t: root mismatch: expected %0d, actual %0d",
                     $time, expected.root, root);
            mismatch_count++;
         end
         if (negative_error !== expected.negative_error) begin
            $display("%0t: negative_error mismatch: expected %0b, actual %0b",
                     $time, expected.negative_error, negative_error);
            mismatch_count++;
         end
      endfunction

   endclass

endpackage

>>> dv/tb_integer_square_root_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the integer square root unit: directed corner operands, then random bursts.
module tb_integer_square_root_unit;

   localparam int RANDOM_ITEMS = 1050;
   localparam int DRAIN_LIMIT  = 200;

   logic                                    clock;
   logic                                    reset;
   logic                                    start;
   logic                                    busy;
   logic signed [isqrt_pkg::DATA_WIDTH-1:0] req_operand;
   logic                                    rsp_valid;
   logic [isqrt_pkg::ROOT_WIDTH-1:0]        rsp_root;
   logic                                    rsp_negative_error;

   root_tracker_pkg::root_tracker tracker;

   integer_square_root_unit uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operand        (req_operand),
      .rsp_valid          (rsp_valid),
      .rsp_root           (rsp_root),
      .rsp_negative_error (rsp_negative_error)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watch both channels at the rising edge: results are checked and accepted items recorded.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            tracker.check_root(rsp_root, rsp_negative_error);
         end
         if (start && !busy) begin
            tracker.note_operand(req_operand);
         end
      end
   end

   // Presents one item from a falling edge and holds it until the unit takes it.
   task automatic send_operand(input logic signed [isqrt_pkg::DATA_WIDTH-1:0] operand);
      start       <= 1'b1;
      req_operand <= operand;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Drops start for a number of cycles, with noise on the operand port.
   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) begin
         req_operand <= $urandom;
         @(negedge clock);
      end
   endtask

   // Draws a random operand, weighted towards squares, small values and the ends of the range.
   function automatic logic signed [isqrt_pkg::DATA_WIDTH-1:0] pick_operand();
      int unsigned base;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick) inside
         [0:3]: begin
            return $urandom;
         end
         [4:5]: begin
            base = $urandom_range(0, 46340);
            return base * base + $urandom_range(0, 2) - 1;
         end
         6: begin
            return $urandom_range(0, 1000);
         end
         7: begin
            return 32'h7FFF_FFFF - $urandom_range(0, 200000);
         end
         default: begin
            return {1'b1, 31'($urandom)};
         end
      endcase
   endfunction

   // Directed items, then random bursts, then drain and report.
   initial begin
      int unsigned burst;
      int unsigned sent;
      int unsigned waited;
      logic signed [isqrt_pkg::DATA_WIDTH-1:0] corner_operands[$];

      tracker     = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_operand = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero, small squares and neighbours, the largest square, the maximum and negatives.
      corner_operands = '{0, 1, 2, 3, 4, 8, 15, 16, 17, 99, 100, 65535, 65536,
                          32'h3FFF_FFFF, 32'h4000_0000, 32'h5555_5555,
                          2147395599, 2147395600, 2147395601, 32'h7FFF_FFFF,
                          -1, -2, 32'h8000_0000, 32'hAAAA_AAAA};
      foreach (corner_operands[i]) begin
         send_operand(corner_operands[i]);
         if ($urandom_range(0, 2) == 0) begin
            pause_sender($urandom_range(1, 20));
         end
      end

      // Random bursts; some long ones run back to back with no gaps at all.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         repeat (burst) begin
            send_operand(pick_operand());
            sent++;
         end
         if (burst < 20) begin
            pause_sender($urandom_range(1, 25));
         end
      end
      pause_sender(1);

      // Wait for every outstanding result, then a little longer for strays.
      waited = 0;
      while (tracker.pending_roots.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);

      if (tracker.pending_roots.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, tracker.pending_roots.size());
      end
      if (tracker.mismatch_count == 0 && tracker.pending_roots.size() == 0) begin
         $display("tb_integer_square_root_unit: clean");
      end else begin
         $display("tb_integer_square_root_unit: errors");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #1000000;
      $display("%0t: timeout", $time);
      $display("tb_integer_square_root_unit: errors");
      $finish;
   end

endmodule
